[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the particle update engine.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define PAS_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("pas assertion failed");

// Checked on every rising clock edge, reset included.
`define PAS_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("pas assertion failed");

`endif

[design/pas_pkg.sv]
// ----------------------------------------------------------------------------
// pas_pkg
// Widths, register codes, reset values and pipeline types of the particle
// update engine.
// ----------------------------------------------------------------------------
package pas_pkg;

    localparam int PosW     = 21;  // Q12.8 position
    localparam int VelW     = 16;  // Q8.8 velocity
    localparam int CrdW     = 12;  // whole-pixel coordinate
    localparam int GainW    = 16;  // Q0.16 factor
    localparam int BurstW   = 15;  // Q7.8 speed
    localparam int DW       = 23;  // signed offset to target
    localparam int MagW     = 21;  // offset magnitude
    localparam int FacW     = 23;  // numerator factor
    localparam int SqW      = 43;  // squared distance
    localparam int RadW     = 60;  // radicand, squared distance in Q.32
    localparam int LenW     = 30;  // distance in Q.16
    localparam int ProdW    = 44;  // magnitude times factor
    localparam int NumW     = 45;  // rounded dividend
    localparam int QW       = 16;  // quotient
    localparam int WW       = 18;  // velocity plus pull
    localparam int SqrtCells = LenW;
    localparam int DivCells  = QW;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;

    localparam logic [CfgIdxW-1:0] CFG_WIDTH  = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_HEIGHT = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_GAIN   = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_DAMP   = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_BURST  = 3'd4;

    localparam logic [CrdW-1:0]   RST_WIDTH  = 12'd1600;
    localparam logic [CrdW-1:0]   RST_HEIGHT = 12'd1000;
    localparam logic [GainW-1:0]  RST_GAIN   = 16'd39322;
    localparam logic [GainW-1:0]  RST_DAMP   = 16'd63570;
    localparam logic [BurstW-1:0] RST_BURST  = 15'd12800;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_BURST = 1'b1;

    // Item data that rides along the arithmetic chains.
    typedef struct packed {
        logic                   func;
        logic signed [PosW-1:0] px;
        logic signed [PosW-1:0] py;
        logic signed [VelW-1:0] vx;
        logic signed [VelW-1:0] vy;
        logic                   neg_x;
        logic                   neg_y;
        logic                   zero;
    } t_side;

    // Dividend magnitudes for both axes.
    typedef struct packed {
        logic [ProdW-1:0] x;
        logic [ProdW-1:0] y;
    } t_num;

endpackage

[design/pas_if.sv]
// ----------------------------------------------------------------------------
// pas_if
// Valid/ready channels for particle items and update results.
// ----------------------------------------------------------------------------
interface pas_in_if import pas_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   func;
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic signed [VelW-1:0] vel_x;
    logic signed [VelW-1:0] vel_y;
    logic [CrdW-1:0]        target_x;
    logic [CrdW-1:0]        target_y;

    modport source (output valid, func, pos_x, pos_y, vel_x, vel_y, target_x, target_y,
                    input ready);
    modport sink   (input valid, func, pos_x, pos_y, vel_x, vel_y, target_x, target_y,
                    output ready);
endinterface

interface pas_out_if import pas_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic signed [PosW-1:0] new_pos_x;
    logic signed [PosW-1:0] new_pos_y;
    logic signed [VelW-1:0] new_vel_x;
    logic signed [VelW-1:0] new_vel_y;
    logic                   out_of_bounds;

    modport source (output valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y,
                    out_of_bounds, input ready);
    modport sink   (input valid, new_pos_x, new_pos_y, new_vel_x, new_vel_y,
                    out_of_bounds, output ready);
endinterface

[design/pas_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// pas_sqrt_cell
// One digit step of the integer square root: settles one root bit.
// ----------------------------------------------------------------------------
module pas_sqrt_cell import pas_pkg::*; #(
    parameter int BitPos = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  t_side           i_side,
    input  t_num            i_num,
    input  logic [RadW-1:0] i_rad,
    input  logic [RadW-1:0] i_root,
    output logic            o_valid,
    output t_side           o_side,
    output t_num            o_num,
    output logic [RadW-1:0] o_rad,
    output logic [RadW-1:0] o_root
);

    localparam logic [RadW-1:0] StepBit = {{(RadW-1){1'b0}}, 1'b1} << BitPos;

    logic [RadW-1:0] trial;
    logic            fits;
    logic [RadW-1:0] n_rad;
    logic [RadW-1:0] n_root;

    // Subtract the trial term when it fits and set the root bit.
    always_comb begin
        trial  = i_root + StepBit;
        fits   = (i_rad >= trial);
        n_rad  = fits ? (i_rad - trial) : i_rad;
        n_root = fits ? ((i_root >> 1) + StepBit) : (i_root >> 1);
    end

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_side <= i_side;
            o_num  <= i_num;
            o_rad  <= n_rad;
            o_root <= n_root;
        end
    end

endmodule

[design/pas_div_cell.sv]
// ----------------------------------------------------------------------------
// pas_div_cell
// One restoring division step for both axes: settles one quotient bit.
// ----------------------------------------------------------------------------
module pas_div_cell import pas_pkg::*; #(
    parameter int Shift = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  t_side           i_side,
    input  logic [LenW-1:0] i_den,
    input  logic [NumW-1:0] i_rem_x,
    input  logic [NumW-1:0] i_rem_y,
    input  logic [QW-1:0]   i_q_x,
    input  logic [QW-1:0]   i_q_y,
    output logic            o_valid,
    output t_side           o_side,
    output logic [LenW-1:0] o_den,
    output logic [NumW-1:0] o_rem_x,
    output logic [NumW-1:0] o_rem_y,
    output logic [QW-1:0]   o_q_x,
    output logic [QW-1:0]   o_q_y
);

    localparam logic [QW-1:0] QBit = {{(QW-1){1'b0}}, 1'b1} << Shift;

    logic [NumW:0] den_sh;
    logic          fit_x;
    logic          fit_y;

    // Compare each remainder with the shifted divisor.
    always_comb begin
        den_sh = {{(NumW+1-LenW){1'b0}}, i_den} << Shift;
        fit_x  = ({1'b0, i_rem_x} >= den_sh);
        fit_y  = ({1'b0, i_rem_y} >= den_sh);
    end

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_side  <= i_side;
            o_den   <= i_den;
            o_rem_x <= fit_x ? (i_rem_x - den_sh[NumW-1:0]) : i_rem_x;
            o_rem_y <= fit_y ? (i_rem_y - den_sh[NumW-1:0]) : i_rem_y;
            o_q_x   <= fit_x ? (i_q_x | QBit) : i_q_x;
            o_q_y   <= fit_y ? (i_q_y | QBit) : i_q_y;
        end
    end

endmodule

[design/particle_attract_step.sv]
// Fully pipelined: one item accepted per cycle while the output is not stalled,
// 53 register stages. Depth is set by the square root chain (30 cells, one
// root bit each) and the divider chain (16 cells, one quotient bit each).
// Reset is synchronous, active low; it empties the pipeline and restores
// the register defaults (1600, 1000, 0.6, 0.97, 50.0).
// ----------------------------------------------------------------------------
// particle_attract_step
// Per-particle update engine: pull toward a target with damping, or burst
// away from it; the pull path adds saturation and a screen bounds check.
// ----------------------------------------------------------------------------
module particle_attract_step import pas_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data,
    pas_in_if.sink              i_item,
    pas_out_if.source           o_res
);

    // ---------------- configuration registers ----------------
    logic [CrdW-1:0]   r_width;
    logic [CrdW-1:0]   r_height;
    logic [GainW-1:0]  r_gain;
    logic [GainW-1:0]  r_damp;
    logic [BurstW-1:0] r_burst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_WIDTH;
            r_height <= RST_HEIGHT;
            r_gain   <= RST_GAIN;
            r_damp   <= RST_DAMP;
            r_burst  <= RST_BURST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WIDTH:  r_width  <= i_cfg_data[CrdW-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[CrdW-1:0];
                CFG_GAIN:   r_gain   <= i_cfg_data[GainW-1:0];
                CFG_DAMP:   r_damp   <= i_cfg_data[GainW-1:0];
                CFG_BURST:  r_burst  <= i_cfg_data[BurstW-1:0];
                default: begin
                end
            endcase
        end
    end

    // ---------------- pipeline advance ----------------
    logic r_o_v;
    logic en;

    // Everything moves unless a waiting result would be overwritten.
    assign en           = ~r_o_v | o_res.ready;
    assign i_item.ready = en;

    // ---------------- stage 0: offset to target ----------------
    logic                 r_s0_v;
    t_side                r_s0_side;
    logic signed [DW-1:0] r_s0_dx;
    logic signed [DW-1:0] r_s0_dy;
    t_side                s0_side;

    always_comb begin
        s0_side.func  = i_item.func;
        s0_side.px    = i_item.pos_x;
        s0_side.py    = i_item.pos_y;
        s0_side.vx    = i_item.vel_x;
        s0_side.vy    = i_item.vel_y;
        s0_side.neg_x = 1'b0;
        s0_side.neg_y = 1'b0;
        s0_side.zero  = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (en) begin
            r_s0_v <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_side <= s0_side;
            r_s0_dx   <= $signed({3'b000, i_item.target_x, 8'h00})
                       - $signed({{(DW-PosW){i_item.pos_x[PosW-1]}}, i_item.pos_x});
            r_s0_dy   <= $signed({3'b000, i_item.target_y, 8'h00})
                       - $signed({{(DW-PosW){i_item.pos_y[PosW-1]}}, i_item.pos_y});
        end
    end

    // ---------------- stage 1: squares and dividends ----------------
    logic              r_s1_v;
    t_side             r_s1_side;
    logic [2*MagW-1:0] r_s1_sqx;
    logic [2*MagW-1:0] r_s1_sqy;
    t_num              r_s1_num;
    logic [DW-1:0]     abs_x_w;
    logic [DW-1:0]     abs_y_w;
    logic [MagW-1:0]   abs_x;
    logic [MagW-1:0]   abs_y;
    logic [FacW-1:0]   factor;
    t_side             s1_side;

    always_comb begin
        abs_x_w = r_s0_dx[DW-1] ? DW'(-r_s0_dx) : DW'(r_s0_dx);
        abs_y_w = r_s0_dy[DW-1] ? DW'(-r_s0_dy) : DW'(r_s0_dy);
        abs_x   = abs_x_w[MagW-1:0];
        abs_y   = abs_y_w[MagW-1:0];
        // Burst divides speed scaled by 256, tick divides the gain.
        factor  = (r_s0_side.func == FUNC_BURST) ? {r_burst, 8'h00}
                                                 : {{(FacW-GainW){1'b0}}, r_gain};
        s1_side       = r_s0_side;
        s1_side.neg_x = r_s0_dx[DW-1];
        s1_side.neg_y = r_s0_dy[DW-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= r_s0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_side  <= s1_side;
            r_s1_sqx   <= abs_x * abs_x;
            r_s1_sqy   <= abs_y * abs_y;
            r_s1_num.x <= abs_x * factor;
            r_s1_num.y <= abs_y * factor;
        end
    end

    // ---------------- stage 2: squared distance ----------------
    logic            r_s2_v;
    t_side           r_s2_side;
    t_num            r_s2_num;
    logic [RadW-1:0] r_s2_rad;
    logic [SqW-1:0]  sq_sum;
    t_side           s2_side;

    always_comb begin
        sq_sum       = {1'b0, r_s1_sqx} + {1'b0, r_s1_sqy};
        s2_side      = r_s1_side;
        s2_side.zero = (sq_sum == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (en) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_side <= s2_side;
            r_s2_num  <= r_s1_num;
            r_s2_rad  <= {{(RadW-SqW-16){1'b0}}, sq_sum, 16'h0000};
        end
    end

    // ---------------- square root chain ----------------
    logic            sq_v    [0:SqrtCells];
    t_side           sq_side [0:SqrtCells];
    t_num            sq_num  [0:SqrtCells];
    logic [RadW-1:0] sq_rad  [0:SqrtCells-1];
    logic [RadW-1:0] sq_root [0:SqrtCells];

    assign sq_v[0]    = r_s2_v;
    assign sq_side[0] = r_s2_side;
    assign sq_num[0]  = r_s2_num;
    assign sq_rad[0]  = r_s2_rad;
    assign sq_root[0] = '0;

    genvar k;
    generate
        for (k = 0; k < SqrtCells; k++) begin : g_sqrt
            if (k < SqrtCells - 1) begin : g_mid
                pas_sqrt_cell #(.BitPos(2 * (SqrtCells - 1 - k))) u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_en    (en),
                    .i_valid (sq_v[k]),
                    .i_side  (sq_side[k]),
                    .i_num   (sq_num[k]),
                    .i_rad   (sq_rad[k]),
                    .i_root  (sq_root[k]),
                    .o_valid (sq_v[k+1]),
                    .o_side  (sq_side[k+1]),
                    .o_num   (sq_num[k+1]),
                    .o_rad   (sq_rad[k+1]),
                    .o_root  (sq_root[k+1])
                );
            end else begin : g_last
                pas_sqrt_cell #(.BitPos(0)) u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_en    (en),
                    .i_valid (sq_v[k]),
                    .i_side  (sq_side[k]),
                    .i_num   (sq_num[k]),
                    .i_rad   (sq_rad[k]),
                    .i_root  (sq_root[k]),
                    .o_valid (sq_v[k+1]),
                    .o_side  (sq_side[k+1]),
                    .o_num   (sq_num[k+1]),
                    .o_rad   (),
                    .o_root  (sq_root[k+1])
                );
            end
        end
    endgenerate

    // ---------------- rounding bias ----------------
    logic            r_rb_v;
    t_side           r_rb_side;
    logic [LenW-1:0] r_rb_den;
    logic [NumW-1:0] r_rb_rem_x;
    logic [NumW-1:0] r_rb_rem_y;
    logic [LenW-1:0] len;
    logic [NumW-1:0] half_len;

    always_comb begin
        len      = sq_root[SqrtCells][LenW-1:0];
        half_len = {{(NumW-LenW+1){1'b0}}, len[LenW-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rb_v <= 1'b0;
        end else if (en) begin
            r_rb_v <= sq_v[SqrtCells];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rb_side  <= sq_side[SqrtCells];
            r_rb_den   <= len;
            r_rb_rem_x <= {{(NumW-ProdW){1'b0}}, sq_num[SqrtCells].x} + half_len;
            r_rb_rem_y <= {{(NumW-ProdW){1'b0}}, sq_num[SqrtCells].y} + half_len;
        end
    end

    // ---------------- divider chain ----------------
    logic            dv_v     [0:DivCells];
    t_side           dv_side  [0:DivCells];
    logic [LenW-1:0] dv_den   [0:DivCells-1];
    logic [NumW-1:0] dv_rem_x [0:DivCells-1];
    logic [NumW-1:0] dv_rem_y [0:DivCells-1];
    logic [QW-1:0]   dv_q_x   [0:DivCells];
    logic [QW-1:0]   dv_q_y   [0:DivCells];

    assign dv_v[0]     = r_rb_v;
    assign dv_side[0]  = r_rb_side;
    assign dv_den[0]   = r_rb_den;
    assign dv_rem_x[0] = r_rb_rem_x;
    assign dv_rem_y[0] = r_rb_rem_y;
    assign dv_q_x[0]   = '0;
    assign dv_q_y[0]   = '0;

    genvar j;
    generate
        for (j = 0; j < DivCells; j++) begin : g_div
            if (j < DivCells - 1) begin : g_mid
                pas_div_cell #(.Shift(DivCells - 1 - j)) u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_en    (en),
                    .i_valid (dv_v[j]),
                    .i_side  (dv_side[j]),
                    .i_den   (dv_den[j]),
                    .i_rem_x (dv_rem_x[j]),
                    .i_rem_y (dv_rem_y[j]),
                    .i_q_x   (dv_q_x[j]),
                    .i_q_y   (dv_q_y[j]),
                    .o_valid (dv_v[j+1]),
                    .o_side  (dv_side[j+1]),
                    .o_den   (dv_den[j+1]),
                    .o_rem_x (dv_rem_x[j+1]),
                    .o_rem_y (dv_rem_y[j+1]),
                    .o_q_x   (dv_q_x[j+1]),
                    .o_q_y   (dv_q_y[j+1])
                );
            end else begin : g_last
                pas_div_cell #(.Shift(0)) u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_en    (en),
                    .i_valid (dv_v[j]),
                    .i_side  (dv_side[j]),
                    .i_den   (dv_den[j]),
                    .i_rem_x (dv_rem_x[j]),
                    .i_rem_y (dv_rem_y[j]),
                    .i_q_x   (dv_q_x[j]),
                    .i_q_y   (dv_q_y[j]),
                    .o_valid (dv_v[j+1]),
                    .o_side  (dv_side[j+1]),
                    .o_den   (),
                    .o_rem_x (),
                    .o_rem_y (),
                    .o_q_x   (dv_q_x[j+1]),
                    .o_q_y   (dv_q_y[j+1])
                );
            end
        end
    endgenerate

    // ---------------- post stage 1: signed pull or burst velocity ----------------
    logic                   r_p1_v;
    t_side                  r_p1_side;
    logic signed [WW-1:0]   r_p1_w_x;
    logic signed [WW-1:0]   r_p1_w_y;
    logic signed [VelW-1:0] r_p1_b_x;
    logic signed [VelW-1:0] r_p1_b_y;
    t_side                  dv_out;
    logic signed [QW:0]     dlt_x;
    logic signed [QW:0]     dlt_y;
    logic signed [WW-1:0]   add_x;
    logic signed [WW-1:0]   add_y;

    always_comb begin
        dv_out = dv_side[DivCells];
        // A burst points away from the target, a tick toward it.
        dlt_x  = (dv_out.neg_x ^ dv_out.func) ? -$signed({1'b0, dv_q_x[DivCells]})
                                              :  $signed({1'b0, dv_q_x[DivCells]});
        dlt_y  = (dv_out.neg_y ^ dv_out.func) ? -$signed({1'b0, dv_q_y[DivCells]})
                                              :  $signed({1'b0, dv_q_y[DivCells]});
        add_x  = dv_out.zero ? '0 : WW'(dlt_x);
        add_y  = dv_out.zero ? '0 : WW'(dlt_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
        end else if (en) begin
            r_p1_v <= dv_v[DivCells];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1_side <= dv_out;
            r_p1_w_x  <= WW'(dv_out.vx) + add_x;
            r_p1_w_y  <= WW'(dv_out.vy) + add_y;
            r_p1_b_x  <= dv_out.zero ? dv_out.vx : dlt_x[VelW-1:0];
            r_p1_b_y  <= dv_out.zero ? dv_out.vy : dlt_y[VelW-1:0];
        end
    end

    // ---------------- post stage 2: damping ----------------
    logic                   r_p2_v;
    t_side                  r_p2_side;
    logic signed [VelW-1:0] r_p2_vx;
    logic signed [VelW-1:0] r_p2_vy;
    logic [WW-1:0]          mag_x_w;
    logic [WW-1:0]          mag_y_w;
    logic [WW+GainW-2:0]    prod_x;
    logic [WW+GainW-2:0]    prod_y;
    logic [WW+GainW-2:0]    rnd_x;
    logic [WW+GainW-2:0]    rnd_y;
    logic [WW-2:0]          dmp_x;
    logic [WW-2:0]          dmp_y;
    logic signed [WW-1:0]   sdm_x;
    logic signed [WW-1:0]   sdm_y;
    logic signed [VelW-1:0] sat_x;
    logic signed [VelW-1:0] sat_y;

    localparam logic signed [WW-1:0] VelMax = WW'((1 << (VelW - 1)) - 1);
    localparam logic signed [WW-1:0] VelMin = -WW'(1 << (VelW - 1));

    always_comb begin
        mag_x_w = r_p1_w_x[WW-1] ? WW'(-r_p1_w_x) : WW'(r_p1_w_x);
        mag_y_w = r_p1_w_y[WW-1] ? WW'(-r_p1_w_y) : WW'(r_p1_w_y);
        prod_x  = mag_x_w[WW-2:0] * r_damp;
        prod_y  = mag_y_w[WW-2:0] * r_damp;
        // Round half away from zero on the magnitude.
        rnd_x   = prod_x + (WW+GainW-1)'(32768);
        rnd_y   = prod_y + (WW+GainW-1)'(32768);
        dmp_x   = rnd_x[WW+GainW-2:GainW];
        dmp_y   = rnd_y[WW+GainW-2:GainW];
        sdm_x   = r_p1_w_x[WW-1] ? -$signed({1'b0, dmp_x}) : $signed({1'b0, dmp_x});
        sdm_y   = r_p1_w_y[WW-1] ? -$signed({1'b0, dmp_y}) : $signed({1'b0, dmp_y});
        sat_x   = (sdm_x > VelMax) ? VelMax[VelW-1:0] :
                  (sdm_x < VelMin) ? VelMin[VelW-1:0] : sdm_x[VelW-1:0];
        sat_y   = (sdm_y > VelMax) ? VelMax[VelW-1:0] :
                  (sdm_y < VelMin) ? VelMin[VelW-1:0] : sdm_y[VelW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_v <= 1'b0;
        end else if (en) begin
            r_p2_v <= r_p1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p2_side <= r_p1_side;
            r_p2_vx   <= (r_p1_side.func == FUNC_BURST) ? r_p1_b_x : sat_x;
            r_p2_vy   <= (r_p1_side.func == FUNC_BURST) ? r_p1_b_y : sat_y;
        end
    end

    // ---------------- output stage: move and bounds ----------------
    logic signed [PosW-1:0] r_o_px;
    logic signed [PosW-1:0] r_o_py;
    logic signed [VelW-1:0] r_o_vx;
    logic signed [VelW-1:0] r_o_vy;
    logic                   r_o_oob;
    logic signed [PosW:0]   sum_x;
    logic signed [PosW:0]   sum_y;
    logic signed [PosW-1:0] mv_x;
    logic signed [PosW-1:0] mv_y;
    logic                   oob;

    localparam logic signed [PosW-1:0] PosMax = {1'b0, {(PosW-1){1'b1}}};
    localparam logic signed [PosW-1:0] PosMin = {1'b1, {(PosW-1){1'b0}}};

    always_comb begin
        sum_x = (PosW+1)'(r_p2_side.px) + (PosW+1)'(r_p2_vx);
        sum_y = (PosW+1)'(r_p2_side.py) + (PosW+1)'(r_p2_vy);
        // Top two bits differ on overflow.
        mv_x  = (sum_x[PosW] == sum_x[PosW-1]) ? sum_x[PosW-1:0] :
                (sum_x[PosW] ? PosMin : PosMax);
        mv_y  = (sum_y[PosW] == sum_y[PosW-1]) ? sum_y[PosW-1:0] :
                (sum_y[PosW] ? PosMin : PosMax);
        oob   = mv_x[PosW-1] | mv_y[PosW-1]
              | (mv_x[PosW-2:0] > {r_width, 8'h00})
              | (mv_y[PosW-2:0] > {r_height, 8'h00});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (en) begin
            r_o_v <= r_p2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_vx <= r_p2_vx;
            r_o_vy <= r_p2_vy;
            if (r_p2_side.func == FUNC_BURST) begin
                r_o_px  <= r_p2_side.px;
                r_o_py  <= r_p2_side.py;
                r_o_oob <= 1'b0;
            end else begin
                r_o_px  <= mv_x;
                r_o_py  <= mv_y;
                r_o_oob <= oob;
            end
        end
    end

    assign o_res.valid         = r_o_v;
    assign o_res.new_pos_x     = r_o_px;
    assign o_res.new_pos_y     = r_o_py;
    assign o_res.new_vel_x     = r_o_vx;
    assign o_res.new_vel_y     = r_o_vy;
    assign o_res.out_of_bounds = r_o_oob;

endmodule

[design/pas_chk.sv]
// ----------------------------------------------------------------------------
// pas_chk
// Port-level checks on the particle update engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pas_chk import pas_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic signed [PosW-1:0] i_out_pos_x,
    input logic signed [VelW-1:0] i_out_vel_x,
    input logic                   i_out_oob
);

    // A result stays offered until it is taken.
    `PAS_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid)

    // A stalled result keeps its payload.
    `PAS_ASSERT(a_out_stable, i_out_valid && !i_out_ready |=> $stable(i_out_pos_x) && $stable(i_out_vel_x) && $stable(i_out_oob))

    // With no result waiting, a new item is always taken.
    `PAS_ASSERT(a_in_free, !i_out_valid |-> i_in_ready)

    // A result being taken never blocks the input side.
    `PAS_ASSERT(a_flow, i_out_valid && i_out_ready |-> i_in_ready)

    // Reset leaves no result offered.
    `PAS_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !i_out_valid)

endmodule

bind particle_attract_step pas_chk u_pas_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_pos_x (o_res.new_pos_x),
    .i_out_vel_x (o_res.new_vel_x),
    .i_out_oob   (o_res.out_of_bounds)
);
